@@ rtl/tce_pkg.sv @@
// Shared types and constants of the tactile contact estimator.
package tce_pkg;

    localparam int TAXELS = 12;
    localparam int TIW = $clog2(TAXELS);
    localparam int IW = $clog2(TAXELS + 1);
    localparam int PW = 16;
    localparam int TW = PW + IW;
    localparam int PRW = 33;
    localparam int SW = PRW + IW;
    localparam int DW = SW + 1;
    localparam int GW = 96;
    localparam int QDEPTH = 2;
    localparam int QAW = 1;
    localparam logic [15:0] NRM_ONE = 16'd16384;
    localparam logic [15:0] THR_RESET = 16'd1024;
    localparam logic CMD_GEOM = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef struct packed {
        logic is_sample;
        logic wr;
        logic [TIW-1:0] idx;
        logic [15:0] pressure;
        logic [GW-1:0] geom;
        logic last;
    } item_t;

endpackage

@@ rtl/tce_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end
endmodule

@@ rtl/tce_div.sv @@
// Bit-serial rounding divider with 16-bit signed saturation of the quotient.
module tce_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic signed [tce_pkg::SW-1:0] num,
    input  logic [tce_pkg::TW-1:0]      den,
    output logic                        done,
    output logic signed [15:0]          quot
);
    localparam int CNTW = $clog2(tce_pkg::DW + 1);

    logic [tce_pkg::DW-1:0] dvd_reg;
    logic [tce_pkg::TW-1:0] rem_reg;
    logic [tce_pkg::TW-1:0] den_reg;
    logic [CNTW-1:0] cnt_reg;
    logic neg_reg;
    logic busy_reg;
    logic done_reg;
    logic [tce_pkg::SW-1:0] mag;
    logic [tce_pkg::TW:0] rem_sh;
    logic fits;

    always_comb begin
        mag = num[tce_pkg::SW-1] ? (~num + 1'b1) : num;
        rem_sh = {rem_reg, dvd_reg[tce_pkg::DW-1]};
        fits = rem_sh >= {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                dvd_reg <= tce_pkg::DW'(mag) + tce_pkg::DW'(den >> 1);
                den_reg <= den;
                rem_reg <= '0;
                neg_reg <= num[tce_pkg::SW-1];
                cnt_reg <= CNTW'(tce_pkg::DW);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= fits ? tce_pkg::TW'(rem_sh - {1'b0, den_reg})
                                : tce_pkg::TW'(rem_sh);
                dvd_reg <= {dvd_reg[tce_pkg::DW-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (neg_reg) begin
            quot = (dvd_reg > tce_pkg::DW'(32768)) ? 16'sh8000
                                                   : $signed(~dvd_reg[15:0] + 16'd1);
        end else begin
            quot = (dvd_reg > tce_pkg::DW'(32767)) ? 16'sh7FFF : $signed(dvd_reg[15:0]);
        end
    end

    assign done = done_reg;
endmodule

@@ rtl/tce_fifo.sv @@
// Short item queue between the front and back sections.
module tce_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  tce_pkg::item_t      push_item,
    output logic                full,
    input  logic                pop,
    output tce_pkg::item_t      head,
    output logic                empty
);
    tce_pkg::item_t ent_reg [tce_pkg::QDEPTH];
    logic [tce_pkg::QAW-1:0] wp_reg;
    logic [tce_pkg::QAW-1:0] rp_reg;
    logic [tce_pkg::QAW:0] cnt_reg;

    assign full = cnt_reg == (tce_pkg::QAW+1)'(tce_pkg::QDEPTH);
    assign empty = cnt_reg == '0;
    assign head = ent_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wp_reg] <= push_item;
        end
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end
endmodule

@@ rtl/tce_front.sv @@
// Input front end: accepts items, classifies them and drops those with no effect.
module tce_front (
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_command,
    input  logic [3:0]          s_taxel_index,
    input  logic [15:0]         s_pressure,
    input  logic signed [15:0]  s_pos_x,
    input  logic signed [15:0]  s_pos_y,
    input  logic signed [15:0]  s_pos_z,
    input  logic signed [15:0]  s_nrm_x,
    input  logic signed [15:0]  s_nrm_y,
    input  logic signed [15:0]  s_nrm_z,
    input  logic                s_last,
    input  logic                q_full,
    output logic                q_push,
    output tce_pkg::item_t      q_item
);
    logic in_range;
    logic is_sample;

    always_comb begin
        is_sample = s_command == tce_pkg::CMD_SAMPLE;
        in_range = 32'(s_taxel_index) < tce_pkg::TAXELS;
        s_ready = !q_full;
        q_item.is_sample = is_sample;
        q_item.wr = in_range;
        q_item.idx = tce_pkg::TIW'(s_taxel_index);
        q_item.pressure = s_pressure;
        q_item.geom = {s_nrm_z, s_nrm_y, s_nrm_x, s_pos_z, s_pos_y, s_pos_x};
        q_item.last = is_sample && s_last;
        // drop out-of-range items unless they close a frame
        q_push = s_valid && !q_full && (in_range || (is_sample && s_last));
    end
endmodule

@@ rtl/tce_back.sv @@
// Back end: stores geometry and pressures and evaluates each frame.
module tce_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic                q_empty,
    input  tce_pkg::item_t      q_head,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_contact,
    output logic [3:0]          m_active_count,
    output logic [19:0]         m_total_pressure,
    output logic signed [15:0]  m_cop_x,
    output logic signed [15:0]  m_cop_y,
    output logic signed [15:0]  m_cop_z,
    output logic signed [15:0]  m_normal_x,
    output logic signed [15:0]  m_normal_y,
    output logic signed [15:0]  m_normal_z,
    output logic [3:0]          m_nearest_taxel
);
    localparam int TIW = tce_pkg::TIW;
    localparam int SW = tce_pkg::SW;

    typedef enum logic [4:0] {
        S_IDLE, S_ARD, S_ACHK, S_AMUL, S_AADD, S_DSEL, S_DGO, S_DWAIT,
        S_MMUL, S_MADD, S_MCHK, S_UCHK, S_UMUL, S_UCMP,
        S_NRD, S_NCHK, S_NMUL, S_NADD, S_NCMP, S_FIN
    } state_t;

    state_t state_reg;
    logic [15:0] thr_reg;
    logic [15:0] pr_reg [tce_pkg::TAXELS];
    logic [TIW-1:0] i_reg;
    logic [2:0] k_reg;
    logic [tce_pkg::TAXELS-1:0] mask_reg;
    logic [tce_pkg::IW-1:0] count_reg;
    logic [tce_pkg::TW-1:0] total_reg;
    logic signed [SW-1:0] sum_reg [6];
    logic signed [33:0] prod_reg;
    logic signed [15:0] cop_reg [3];
    logic signed [15:0] a_reg [3];
    logic [30:0] asq_reg [3];
    logic [31:0] m_reg;
    logic [14:0] lo_reg;
    logic [14:0] hi_reg;
    logic [14:0] mid_reg;
    logic [29:0] tt_reg;
    logic [61:0] big_reg;
    logic signed [15:0] nrm_reg [3];
    logic [35:0] d_reg;
    logic [35:0] best_reg;
    logic found_reg;
    logic [TIW-1:0] near_reg;
    logic m_valid_reg;
    logic [3:0] o_count_reg;
    logic [19:0] o_total_reg;
    logic signed [15:0] o_cop_reg [3];
    logic signed [15:0] o_nrm_reg [3];
    logic [3:0] o_near_reg;

    logic [tce_pkg::GW-1:0] geo;
    logic ram_we;
    logic [1:0] k2;
    logic [15:0] cur_p;
    logic signed [15:0] comp;
    logic signed [32:0] mul_a;
    logic signed [31:0] mul_m;
    logic signed [16:0] e;
    logic signed [33:0] mul_n;
    logic [14:0] mid;
    logic [14:0] t;
    logic div_start;
    logic div_done;
    logic signed [15:0] div_q;
    logic last_taxel;
    logic out_free;

    assign ram_we = (state_reg == S_IDLE) && !q_empty && !q_head.is_sample && q_head.wr;
    assign q_pop = (state_reg == S_IDLE) && !q_empty;
    assign div_start = state_reg == S_DGO;

    tce_ram #(.WIDTH(tce_pkg::GW), .DEPTH(tce_pkg::TAXELS)) u_geo (
        .aclk(aclk),
        .wr_en(ram_we),
        .wr_addr(q_head.idx),
        .wr_data(q_head.geom),
        .rd_addr(i_reg),
        .rd_data(geo)
    );

    tce_div u_div (
        .aclk(aclk),
        .aresetn(aresetn),
        .start(div_start),
        .num(sum_reg[k_reg]),
        .den(total_reg),
        .done(div_done),
        .quot(div_q)
    );

    always_comb begin
        k2 = k_reg[1:0];
        cur_p = pr_reg[i_reg];
        comp = $signed(geo[k_reg*16 +: 16]);
        mul_a = $signed({1'b0, cur_p}) * comp;
        mul_m = a_reg[k2] * a_reg[k2];
        e = {cop_reg[k2][15], cop_reg[k2]} - {comp[15], comp};
        mul_n = e * e;
        mid = 15'(({1'b0, lo_reg} + {1'b0, hi_reg} + 16'd1) >> 1);
        t = 15'({mid, 1'b0} - 16'd1);
        last_taxel = i_reg == TIW'(tce_pkg::TAXELS - 1);
        out_free = !m_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            thr_reg <= tce_pkg::THR_RESET;
            m_valid_reg <= 1'b0;
            for (int j = 0; j < tce_pkg::TAXELS; j++) begin
                pr_reg[j] <= '0;
            end
        end else begin
            if (cfg_we) begin
                thr_reg <= cfg_wdata;
            end
            // the final state reloads the output register itself
            if (m_valid_reg && m_ready && state_reg != S_FIN) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (!q_empty && q_head.is_sample) begin
                        if (q_head.wr) begin
                            pr_reg[q_head.idx] <= q_head.pressure;
                        end
                        if (q_head.last) begin
                            mask_reg <= '0;
                            count_reg <= '0;
                            total_reg <= '0;
                            for (int j = 0; j < 6; j++) begin
                                sum_reg[j] <= '0;
                            end
                            i_reg <= '0;
                            state_reg <= S_ARD;
                        end
                    end
                end
                S_ARD: state_reg <= S_ACHK;
                S_ACHK: begin
                    if (cur_p >= thr_reg) begin
                        mask_reg[i_reg] <= 1'b1;
                        count_reg <= count_reg + 1'b1;
                        total_reg <= total_reg + tce_pkg::TW'(cur_p);
                        k_reg <= '0;
                        state_reg <= S_AMUL;
                    end else if (last_taxel) begin
                        state_reg <= S_DSEL;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                        state_reg <= S_ARD;
                    end
                end
                S_AMUL: begin
                    prod_reg <= {mul_a[32], mul_a};
                    state_reg <= S_AADD;
                end
                S_AADD: begin
                    sum_reg[k_reg] <= sum_reg[k_reg] + SW'(prod_reg);
                    if (k_reg != 3'd5) begin
                        k_reg <= k_reg + 1'b1;
                        state_reg <= S_AMUL;
                    end else if (last_taxel) begin
                        state_reg <= S_DSEL;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                        state_reg <= S_ARD;
                    end
                end
                S_DSEL: begin
                    k_reg <= '0;
                    if (count_reg == '0 || total_reg == '0) begin
                        for (int j = 0; j < 3; j++) begin
                            cop_reg[j] <= '0;
                            nrm_reg[j] <= '0;
                        end
                        nrm_reg[0] <= tce_pkg::NRM_ONE;
                        i_reg <= '0;
                        found_reg <= 1'b0;
                        near_reg <= '0;
                        state_reg <= S_NRD;
                    end else begin
                        state_reg <= S_DGO;
                    end
                end
                S_DGO: state_reg <= S_DWAIT;
                S_DWAIT: begin
                    if (div_done) begin
                        if (k_reg < 3'd3) begin
                            cop_reg[k2] <= div_q;
                        end else begin
                            a_reg[2'(k_reg - 3'd3)] <= div_q;
                        end
                        if (k_reg == 3'd5) begin
                            k_reg <= '0;
                            m_reg <= '0;
                            state_reg <= S_MMUL;
                        end else begin
                            k_reg <= k_reg + 1'b1;
                            state_reg <= S_DGO;
                        end
                    end
                end
                S_MMUL: begin
                    prod_reg <= 34'(mul_m);
                    asq_reg[k2] <= mul_m[30:0];
                    state_reg <= S_MADD;
                end
                S_MADD: begin
                    m_reg <= m_reg + prod_reg[31:0];
                    if (k_reg == 3'd2) begin
                        state_reg <= S_MCHK;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                        state_reg <= S_MMUL;
                    end
                end
                S_MCHK: begin
                    k_reg <= '0;
                    lo_reg <= '0;
                    hi_reg <= 15'(tce_pkg::NRM_ONE);
                    if (m_reg == '0) begin
                        nrm_reg[0] <= tce_pkg::NRM_ONE;
                        nrm_reg[1] <= '0;
                        nrm_reg[2] <= '0;
                        i_reg <= '0;
                        found_reg <= 1'b0;
                        near_reg <= '0;
                        state_reg <= S_NRD;
                    end else begin
                        state_reg <= S_UCHK;
                    end
                end
                S_UCHK: begin
                    if (lo_reg == hi_reg) begin
                        nrm_reg[k2] <= a_reg[k2][15] ? $signed(~{1'b0, lo_reg} + 16'd1)
                                                     : $signed({1'b0, lo_reg});
                        lo_reg <= '0;
                        hi_reg <= 15'(tce_pkg::NRM_ONE);
                        if (k_reg == 3'd2) begin
                            i_reg <= '0;
                            found_reg <= 1'b0;
                            near_reg <= '0;
                            state_reg <= S_NRD;
                        end else begin
                            k_reg <= k_reg + 1'b1;
                        end
                    end else begin
                        mid_reg <= mid;
                        tt_reg <= t * t;
                        state_reg <= S_UMUL;
                    end
                end
                S_UMUL: begin
                    big_reg <= 62'(tt_reg) * 62'(m_reg);
                    state_reg <= S_UCMP;
                end
                S_UCMP: begin
                    // keep the largest candidate whose rounded square still fits
                    if (big_reg <= {1'b0, asq_reg[k2], 30'b0}) begin
                        lo_reg <= mid_reg;
                    end else begin
                        hi_reg <= mid_reg - 1'b1;
                    end
                    state_reg <= S_UCHK;
                end
                S_NRD: state_reg <= S_NCHK;
                S_NCHK: begin
                    if (mask_reg[i_reg]) begin
                        k_reg <= '0;
                        d_reg <= '0;
                        state_reg <= S_NMUL;
                    end else if (last_taxel) begin
                        state_reg <= S_FIN;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                        state_reg <= S_NRD;
                    end
                end
                S_NMUL: begin
                    prod_reg <= mul_n;
                    state_reg <= S_NADD;
                end
                S_NADD: begin
                    d_reg <= d_reg + 36'(prod_reg);
                    if (k_reg == 3'd2) begin
                        state_reg <= S_NCMP;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                        state_reg <= S_NMUL;
                    end
                end
                S_NCMP: begin
                    if (!found_reg || d_reg < best_reg) begin
                        found_reg <= 1'b1;
                        best_reg <= d_reg;
                        near_reg <= i_reg;
                    end
                    if (last_taxel) begin
                        state_reg <= S_FIN;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                        state_reg <= S_NRD;
                    end
                end
                S_FIN: begin
                    // hold the result until the output register frees up
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        o_count_reg <= (32'(count_reg) > 32'd15) ? 4'd15 : 4'(count_reg);
                        o_total_reg <= (32'(total_reg) > 32'hFFFFF) ? 20'hFFFFF
                                                                    : 20'(total_reg);
                        for (int j = 0; j < 3; j++) begin
                            o_cop_reg[j] <= cop_reg[j];
                            o_nrm_reg[j] <= nrm_reg[j];
                        end
                        o_near_reg <= 4'(near_reg);
                        for (int j = 0; j < tce_pkg::TAXELS; j++) begin
                            pr_reg[j] <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_contact = o_count_reg != '0;
    assign m_active_count = o_count_reg;
    assign m_total_pressure = o_total_reg;
    assign m_cop_x = o_cop_reg[0];
    assign m_cop_y = o_cop_reg[1];
    assign m_cop_z = o_cop_reg[2];
    assign m_normal_x = o_nrm_reg[0];
    assign m_normal_y = o_nrm_reg[1];
    assign m_normal_z = o_nrm_reg[2];
    assign m_nearest_taxel = o_near_reg;
endmodule

@@ rtl/tactile_contact_estimator_top.sv @@
// Top level of the tactile contact estimator.
//
// Input channel s_*: command 0 loads one taxel's position and normal, command 1
// carries one pressure sample; a sample with s_last set closes the frame.
// Result channel m_*: one item per closed frame with contact flag, active count,
// total pressure, centre of pressure, normalized contact normal, nearest taxel.
// cfg_we/cfg_wdata write the contact threshold (reset value 1024).
// Items pass through a two-entry queue; the back end retires a geometry load or
// a non-closing sample while idle. A closing sample starts an evaluation that
// accumulates over the active taxels, runs six serial divisions, performs up to
// three binary searches of 15 steps for the normal, and searches the active
// taxels for the one nearest the centre of pressure.
// Reset clears the queue and the frame pressures and resets the threshold;
// geometry must be loaded before use. When the receiver stalls, the result
// waits in the output register, the evaluation waits at its end, and the
// queue fills and drops s_ready.
module tactile_contact_estimator_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_command,
    input  logic [3:0]          s_taxel_index,
    input  logic [15:0]         s_pressure,
    input  logic signed [15:0]  s_pos_x,
    input  logic signed [15:0]  s_pos_y,
    input  logic signed [15:0]  s_pos_z,
    input  logic signed [15:0]  s_nrm_x,
    input  logic signed [15:0]  s_nrm_y,
    input  logic signed [15:0]  s_nrm_z,
    input  logic                s_last,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_contact,
    output logic [3:0]          m_active_count,
    output logic [19:0]         m_total_pressure,
    output logic signed [15:0]  m_cop_x,
    output logic signed [15:0]  m_cop_y,
    output logic signed [15:0]  m_cop_z,
    output logic signed [15:0]  m_normal_x,
    output logic signed [15:0]  m_normal_y,
    output logic signed [15:0]  m_normal_z,
    output logic [3:0]          m_nearest_taxel
);
    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_empty;
    tce_pkg::item_t q_item;
    tce_pkg::item_t q_head;

    tce_front u_front (
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_command(s_command),
        .s_taxel_index(s_taxel_index),
        .s_pressure(s_pressure),
        .s_pos_x(s_pos_x),
        .s_pos_y(s_pos_y),
        .s_pos_z(s_pos_z),
        .s_nrm_x(s_nrm_x),
        .s_nrm_y(s_nrm_y),
        .s_nrm_z(s_nrm_z),
        .s_last(s_last),
        .q_full(q_full),
        .q_push(q_push),
        .q_item(q_item)
    );

    tce_fifo u_fifo (
        .aclk(aclk),
        .aresetn(aresetn),
        .push(q_push),
        .push_item(q_item),
        .full(q_full),
        .pop(q_pop),
        .head(q_head),
        .empty(q_empty)
    );

    tce_back u_back (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .q_empty(q_empty),
        .q_head(q_head),
        .q_pop(q_pop),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_contact(m_contact),
        .m_active_count(m_active_count),
        .m_total_pressure(m_total_pressure),
        .m_cop_x(m_cop_x),
        .m_cop_y(m_cop_y),
        .m_cop_z(m_cop_z),
        .m_normal_x(m_normal_x),
        .m_normal_y(m_normal_y),
        .m_normal_z(m_normal_z),
        .m_nearest_taxel(m_nearest_taxel)
    );

    a_contact_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_contact == (m_active_count != 4'd0)))
        else $error("contact flag disagrees with active count");

    a_no_contact: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_contact) |-> (m_nearest_taxel == 4'd0 &&
            m_normal_x == tce_pkg::NRM_ONE && m_total_pressure == 20'd0))
        else $error("no-contact result not in its default form");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");
endmodule

@@ tb/tce_checker.sv @@
// Checker for the tactile contact estimator: predicts each frame result and compares.
`timescale 1ns / 1ps

module tce_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_command,
    input  logic [3:0]         s_taxel_index,
    input  logic [15:0]        s_pressure,
    input  logic signed [15:0] s_pos_x,
    input  logic signed [15:0] s_pos_y,
    input  logic signed [15:0] s_pos_z,
    input  logic signed [15:0] s_nrm_x,
    input  logic signed [15:0] s_nrm_y,
    input  logic signed [15:0] s_nrm_z,
    input  logic               s_last,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_contact,
    input  logic [3:0]         m_active_count,
    input  logic [19:0]        m_total_pressure,
    input  logic signed [15:0] m_cop_x,
    input  logic signed [15:0] m_cop_y,
    input  logic signed [15:0] m_cop_z,
    input  logic signed [15:0] m_normal_x,
    input  logic signed [15:0] m_normal_y,
    input  logic signed [15:0] m_normal_z,
    input  logic [3:0]         m_nearest_taxel,
    output int                 fail_count,
    output int                 pending
);

    typedef struct {
        logic               contact;
        logic [3:0]         count;
        logic [19:0]        total;
        logic signed [15:0] cop [3];
        logic signed [15:0] nrm [3];
        logic [3:0]         nearest;
    } contact_result_t;

    logic [15:0]        threshold;
    logic signed [15:0] taxel_pos [tce_pkg::TAXELS][3];
    logic signed [15:0] taxel_nrm [tce_pkg::TAXELS][3];
    logic [15:0]        frame_p [tce_pkg::TAXELS];
    contact_result_t    frame_results [$];

    assign pending = frame_results.size();

    initial fail_count = 0;

    // round to nearest, ties away from zero; den > 0
    function automatic longint div_near(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint clamp_s16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // largest r in 0..16384 with r == 0 or (2r-1)^2 * m <= (32768*a)^2
    function automatic longint unit_part(longint a, longint unsigned m);
        longint unsigned mag;
        longint unsigned rhs;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned t;
        mag = (a < 0) ? -a : a;
        rhs = (32768 * mag) * (32768 * mag);
        lo = 0;
        hi = 16384;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t = 2 * mid - 1;
            if (t * t * m <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return (a < 0) ? -longint'(lo) : longint'(lo);
    endfunction

    function automatic contact_result_t evaluate_frame();
        contact_result_t r;
        logic [tce_pkg::TAXELS-1:0] act;
        longint count;
        longint total;
        longint wpos [3];
        longint wnrm [3];
        longint cop [3];
        longint av [3];
        longint nv [3];
        longint unsigned m;
        longint unsigned d;
        longint unsigned best;
        longint e;
        longint nearest;
        bit found;
        act = '0;
        count = 0;
        total = 0;
        m = 0;
        best = 0;
        nearest = 0;
        found = 0;
        for (int k = 0; k < 3; k++) begin
            wpos[k] = 0;
            wnrm[k] = 0;
            cop[k] = 0;
            nv[k] = 0;
        end
        nv[0] = 16384;
        for (int i = 0; i < tce_pkg::TAXELS; i++) begin
            if (frame_p[i] >= threshold) begin
                act[i] = 1'b1;
                count++;
                total += frame_p[i];
                for (int k = 0; k < 3; k++) begin
                    wpos[k] += longint'(frame_p[i]) * longint'(taxel_pos[i][k]);
                    wnrm[k] += longint'(frame_p[i]) * longint'(taxel_nrm[i][k]);
                end
            end
        end
        if (count > 0 && total > 0) begin
            for (int k = 0; k < 3; k++) begin
                cop[k] = clamp_s16(div_near(wpos[k], total));
                av[k] = clamp_s16(div_near(wnrm[k], total));
                m += longint'(av[k] * av[k]);
            end
            if (m > 0)
                for (int k = 0; k < 3; k++) nv[k] = unit_part(av[k], m);
        end
        for (int i = 0; i < tce_pkg::TAXELS; i++) begin
            if (act[i]) begin
                d = 0;
                for (int k = 0; k < 3; k++) begin
                    e = cop[k] - longint'(taxel_pos[i][k]);
                    d += longint'(e * e);
                end
                if (!found || d < best) begin
                    found = 1;
                    best = d;
                    nearest = i;
                end
            end
        end
        r.contact = (count > 0);
        r.count = (count > 15) ? 4'd15 : count[3:0];
        r.total = (total > 20'hFFFFF) ? 20'hFFFFF : total[19:0];
        for (int k = 0; k < 3; k++) begin
            r.cop[k] = cop[k][15:0];
            r.nrm[k] = nv[k][15:0];
        end
        r.nearest = nearest[3:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0d want %0d at %0t", field, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        contact_result_t want;
        if (!aresetn) begin
            threshold = tce_pkg::THR_RESET;
            for (int i = 0; i < tce_pkg::TAXELS; i++) frame_p[i] = '0;
        end else begin
            if (cfg_we) threshold = cfg_wdata;
            if (m_valid && m_ready) begin
                if (frame_results.size() == 0) begin
                    report_mismatch("unexpected item", 1, 0);
                end else begin
                    want = frame_results.pop_front();
                    if (m_contact !== want.contact)
                        report_mismatch("contact", m_contact, want.contact);
                    if (m_active_count !== want.count)
                        report_mismatch("active_count", m_active_count, want.count);
                    if (m_total_pressure !== want.total)
                        report_mismatch("total_pressure", m_total_pressure, want.total);
                    if (m_cop_x !== want.cop[0]) report_mismatch("cop_x", m_cop_x, want.cop[0]);
                    if (m_cop_y !== want.cop[1]) report_mismatch("cop_y", m_cop_y, want.cop[1]);
                    if (m_cop_z !== want.cop[2]) report_mismatch("cop_z", m_cop_z, want.cop[2]);
                    if (m_normal_x !== want.nrm[0])
                        report_mismatch("normal_x", m_normal_x, want.nrm[0]);
                    if (m_normal_y !== want.nrm[1])
                        report_mismatch("normal_y", m_normal_y, want.nrm[1]);
                    if (m_normal_z !== want.nrm[2])
                        report_mismatch("normal_z", m_normal_z, want.nrm[2]);
                    if (m_nearest_taxel !== want.nearest)
                        report_mismatch("nearest_taxel", m_nearest_taxel, want.nearest);
                end
            end
            if (s_valid && s_ready) begin
                if (s_command == tce_pkg::CMD_GEOM) begin
                    if (s_taxel_index < tce_pkg::TAXELS) begin
                        taxel_pos[s_taxel_index][0] = s_pos_x;
                        taxel_pos[s_taxel_index][1] = s_pos_y;
                        taxel_pos[s_taxel_index][2] = s_pos_z;
                        taxel_nrm[s_taxel_index][0] = s_nrm_x;
                        taxel_nrm[s_taxel_index][1] = s_nrm_y;
                        taxel_nrm[s_taxel_index][2] = s_nrm_z;
                    end
                end else begin
                    if (s_taxel_index < tce_pkg::TAXELS) frame_p[s_taxel_index] = s_pressure;
                    if (s_last) begin
                        frame_results.insert(frame_results.size(), evaluate_frame());
                        for (int i = 0; i < tce_pkg::TAXELS; i++) frame_p[i] = '0;
                    end
                end
            end
        end
    end

endmodule

@@ tb/tb.sv @@
// Testbench top: drives frames and geometry into the contact estimator and gives the verdict.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 1000;
    localparam int HOLD_CYCLES = 4000;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [15:0]        cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic               s_command;
    logic [3:0]         s_taxel_index;
    logic [15:0]        s_pressure;
    logic signed [15:0] s_pos_x, s_pos_y, s_pos_z;
    logic signed [15:0] s_nrm_x, s_nrm_y, s_nrm_z;
    logic               s_last;
    logic               m_valid;
    logic               m_ready;
    logic               m_contact;
    logic [3:0]         m_active_count;
    logic [19:0]        m_total_pressure;
    logic signed [15:0] m_cop_x, m_cop_y, m_cop_z;
    logic signed [15:0] m_normal_x, m_normal_y, m_normal_z;
    logic [3:0]         m_nearest_taxel;
    int                 fail_count;
    int                 pending;
    int                 cycles;
    bit                 quiet;
    bit                 hold_req;
    logic [15:0]        cur_thr;

    tactile_contact_estimator_top u_top (.*);

    tce_checker u_chk (.*);

    initial begin
        aclk = 1'b0;
    end

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off on request, none when quiet
    initial begin
        m_ready = 1'b0;
        forever begin
            if (quiet) begin
                @(negedge aclk) m_ready = 1'b1;
            end else if (hold_req) begin
                @(negedge aclk) m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 0;
            end else if ($urandom_range(0, 1)) begin
                @(negedge aclk) m_ready = 1'b1;
                repeat ($urandom_range(0, 19)) @(negedge aclk);
            end else begin
                @(negedge aclk) m_ready = 1'b0;
                repeat ($urandom_range(0, 10)) @(negedge aclk);
            end
        end
    end

    task automatic send_item(logic cmd, logic [3:0] idx, logic [15:0] p,
                             logic [15:0] px, logic [15:0] py, logic [15:0] pz,
                             logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                             logic lst);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            @(negedge aclk) s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_command = cmd;
        s_taxel_index = idx;
        s_pressure = p;
        s_pos_x = px;
        s_pos_y = py;
        s_pos_z = pz;
        s_nrm_x = nx;
        s_nrm_y = ny;
        s_nrm_z = nz;
        s_last = lst;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic sample(logic [3:0] idx, logic [15:0] p, logic lst);
        send_item(tce_pkg::CMD_SAMPLE, idx, p, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom), lst);
    endtask

    function automatic logic [15:0] rand_nrm();
        case ($urandom_range(0, 3))
            0: return 16'sd16384;
            1: return -16'sd16384;
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    task automatic load_geom(logic [3:0] idx);
        send_item(tce_pkg::CMD_GEOM, idx, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), rand_nrm(), rand_nrm(), rand_nrm(),
                  1'($urandom_range(0, 1)));
    endtask

    function automatic logic [15:0] rand_pressure();
        int v;
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2, 3: begin
                v = int'(cur_thr) + $urandom_range(0, 6) - 3;
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
                return v[15:0];
            end
            default: return 16'($urandom);
        endcase
    endfunction

    // drop valid, wait out all results, then let trailing items drain
    task automatic wait_idle();
        @(negedge aclk) s_valid = 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_threshold(logic [15:0] v);
        wait_idle();
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_wdata = v;
        cur_thr = v;
        @(negedge aclk) cfg_we = 1'b0;
    endtask

    task automatic random_frame(output int used);
        int len;
        len = $urandom_range(1, 14);
        used = len;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                load_geom(4'($urandom_range(0, 15)));
                used++;
            end
            if ($urandom_range(0, 15) == 0)
                sample(4'($urandom_range(12, 15)), 16'($urandom), i == len - 1);
            else
                sample(4'($urandom_range(0, tce_pkg::TAXELS - 1)), rand_pressure(),
                       i == len - 1);
        end
    endtask

    initial begin
        logic [15:0] phase_thr [7];
        int sent;
        int used;
        cycles = 0;
        quiet = 0;
        hold_req = 0;
        cur_thr = tce_pkg::THR_RESET;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_command = tce_pkg::CMD_SAMPLE;
        s_taxel_index = '0;
        s_pressure = '0;
        s_pos_x = '0;
        s_pos_y = '0;
        s_pos_z = '0;
        s_nrm_x = '0;
        s_nrm_y = '0;
        s_nrm_z = '0;
        s_last = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk) aresetn = 1'b1;

        // geometry for every taxel, extremes on the first two
        send_item(tce_pkg::CMD_GEOM, 4'd0, 16'd0, 16'h8000, 16'h7FFF, 16'd0,
                  16'sd16384, 16'd0, 16'd0, 1'b0);
        send_item(tce_pkg::CMD_GEOM, 4'd1, 16'd0, 16'h7FFF, 16'h8000, 16'd0,
                  -16'sd16384, 16'd0, 16'd0, 1'b0);
        for (int i = 2; i < tce_pkg::TAXELS; i++) load_geom(4'(i));
        send_item(tce_pkg::CMD_GEOM, 4'd15, 16'd0, 16'd0, 16'd0, 16'd0,
                  16'd0, 16'd0, 16'd0, 1'b0);
        // no contact: a lone out-of-range sample closes the frame
        sample(4'd15, 16'hFFFF, 1'b1);
        // opposite normals at equal pressure cancel
        sample(4'd0, 16'd5000, 1'b0);
        sample(4'd1, 16'd5000, 1'b1);
        // repeated sample replaces the earlier one
        sample(4'd3, 16'hFFFF, 1'b0);
        sample(4'd3, 16'd10, 1'b1);
        // geometry changed mid-frame
        sample(4'd2, 16'd3000, 1'b0);
        load_geom(4'd2);
        sample(4'd4, 16'd2000, 1'b1);
        // threshold right at a sample
        sample(4'd5, tce_pkg::THR_RESET, 1'b0);
        sample(4'd6, 16'(tce_pkg::THR_RESET - 16'd1), 1'b1);

        write_threshold(16'd0);
        // active taxels with zero total
        sample(4'd7, 16'd0, 1'b1);
        for (int i = 0; i < tce_pkg::TAXELS; i++)
            sample(4'(i), 16'hFFFF, i == tce_pkg::TAXELS - 1);

        write_threshold(16'hFFFF);
        sample(4'd8, 16'hFFFE, 1'b0);
        sample(4'd9, 16'hFFFF, 1'b1);

        phase_thr[0] = tce_pkg::THR_RESET;
        phase_thr[1] = 16'd1;
        phase_thr[2] = 16'($urandom);
        phase_thr[3] = 16'd0;
        phase_thr[4] = 16'hFFFF;
        phase_thr[5] = 16'($urandom_range(0, 4096));
        phase_thr[6] = 16'($urandom);
        for (int ph = 0; ph < 7; ph++) begin
            write_threshold(phase_thr[ph]);
            if (ph == 1) hold_req = 1;
            if (ph == 6) quiet = 1;
            sent = 0;
            while (sent < 250) begin
                random_frame(used);
                sent += used;
            end
        end

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ tactile_contact_estimator_top.f @@
rtl/tce_pkg.sv
rtl/tce_ram.sv
rtl/tce_div.sv
rtl/tce_fifo.sv
rtl/tce_front.sv
rtl/tce_back.sv
rtl/tactile_contact_estimator_top.sv
tb/tce_checker.sv
tb/tb.sv
